>>> rtl/core/chvp_pkg.sv
// shared types and constants for the cookie header value parser
// no dependencies; imported by every module of the block
package chvp_pkg;

  // parser states
  typedef enum logic [2:0] {
    ST_OWS_START = 3'd0,
    ST_NAME      = 3'd1,
    ST_VALUE     = 3'd2,
    ST_SEP       = 3'd3,
    ST_OWS_END   = 3'd4,
    ST_ERROR     = 3'd5
  } parse_state_t;

  // tag carried with each echoed byte
  typedef enum logic [1:0] {
    KIND_SEP   = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_VALUE = 2'd2
  } kind_t;

  // character constants
  localparam logic [7:0] CH_EQ       = 8'h3D;  // '='
  localparam logic [7:0] CH_SEMI     = 8'h3B;  // ';'
  localparam logic [7:0] CH_SPACE    = 8'h20;  // ' '
  localparam logic [7:0] CH_TAB      = 8'h09;  // tab
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
  localparam logic [7:0] CH_COMMA    = 8'h2C;  // ','
  localparam logic [7:0] CH_DQUOTE   = 8'h22;  // '"'
  localparam logic [7:0] CH_BSLASH   = 8'h5C;  // backslash

  // byte class flags from the classifier
  typedef struct packed {
    logic is_ws;
    logic is_token;
    logic is_value;
    logic is_eq;
    logic is_semi;
  } byte_class_t;

  // per-byte result from the state machine
  typedef struct packed {
    kind_t kind;
    logic  pair_done;
    logic  error;
  } chvp_res_t;

endpackage

>>> rtl/core/chvp_byte_class.sv
// byte classifier: whitespace, token, cookie octet and punctuation flags
// depends on chvp_pkg
module chvp_byte_class (
  input  logic [7:0]           data_byte,
  output chvp_pkg::byte_class_t cls
);
  import chvp_pkg::*;

  logic tok_special;

  always_comb begin
    case (data_byte)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,   // ! # $ % & '
      8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F,   // * + - . ^ _
      8'h60, 8'h7C, 8'h7E: tok_special = 1'b1;     // ` | ~
      default:             tok_special = 1'b0;
    endcase
  end

  always_comb begin
    cls.is_ws    = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
    cls.is_token = ((data_byte >= 8'h30) && (data_byte <= 8'h39)) ||  // digits
                   ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ||  // upper case
                   ((data_byte >= 8'h61) && (data_byte <= 8'h7A)) ||  // lower case
                   tok_special;
    cls.is_value = !((data_byte <= CH_CTRL_MAX) || (data_byte == CH_DEL) ||
                     (data_byte == CH_DQUOTE) || (data_byte == CH_COMMA) ||
                     (data_byte == CH_SEMI) || (data_byte == CH_BSLASH));
    cls.is_eq    = (data_byte == CH_EQ);
    cls.is_semi  = (data_byte == CH_SEMI);
  end

endmodule

>>> rtl/core/chvp_fsm.sv
// grammar state machine: state register, next state and per-byte tags
// depends on chvp_pkg
module chvp_fsm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  chvp_pkg::byte_class_t  cls,
  input  logic                   last,
  output chvp_pkg::chvp_res_t    res,
  output chvp_pkg::parse_state_t state
);
  import chvp_pkg::*;

  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_OWS_START;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    res.kind      = KIND_SEP;
    res.pair_done = 1'b0;
    bad           = 1'b0;
    case (state_r)
      ST_OWS_START: begin
        if (cls.is_token) begin
          res.kind  = KIND_NAME;
          state_nxt = ST_NAME;
        end else if (!cls.is_ws) begin
          bad = 1'b1;
        end
      end
      ST_NAME: begin
        if (cls.is_eq) begin
          state_nxt = ST_VALUE;
        end else if (cls.is_token) begin
          res.kind = KIND_NAME;
        end else begin
          bad = 1'b1;
        end
      end
      ST_VALUE: begin
        if (cls.is_semi) begin
          res.pair_done = 1'b1;
          state_nxt     = ST_SEP;
        end else if (cls.is_ws) begin
          res.pair_done = 1'b1;
          state_nxt     = ST_OWS_END;
        end else if (cls.is_value) begin
          res.kind = KIND_VALUE;
        end else begin
          bad = 1'b1;
        end
      end
      ST_SEP: begin
        if (cls.is_ws) begin
          state_nxt = ST_NAME;
        end else begin
          bad = 1'b1;
        end
      end
      ST_OWS_END: begin
        if (!cls.is_ws) begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    if (bad) begin
      state_nxt     = ST_ERROR;
      res.kind      = KIND_SEP;
      res.pair_done = 1'b0;
    end

    // final byte: a value closes its pair, anything but trailing space is malformed
    if (last) begin
      if (state_nxt == ST_VALUE) begin
        res.pair_done = 1'b1;
      end else if (state_nxt != ST_OWS_END) begin
        bad           = 1'b1;
        res.kind      = KIND_SEP;
        res.pair_done = 1'b0;
      end
      state_nxt = ST_OWS_START;
    end

    res.error = bad;
  end

  assign state = state_r;

endmodule

>>> rtl/core/cookie_header_value_parser_unit.sv
// top level of the cookie header value parser: input register, classifier,
// state machine and result register; depends on chvp_pkg, chvp_byte_class, chvp_fsm
//
//  channel | dir | transfer on          | contents
//  --------+-----+----------------------+----------------------------------------
//  in_     | in  | in_tvalid & tready   | tdata: data_byte; tlast: last
//  out_    | out | out_tvalid & tready  | tdata: echo_byte; tuser: kind,
//          |     |                      | pair_done, error; tlast: end_of_value
//
// one byte per cycle sustained while out_tready stays high; a byte passes the input
// register and then the result register; the single state register is updated as a
// byte leaves the input register for the result register
// rst_n is synchronous, active low; it empties both registers and returns the
// parser to leading whitespace
// a stalled output holds its result while the input register still takes one
// more byte; in_tready then follows out_tready
module cookie_header_value_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] echo_byte
  output logic [3:0] out_tuser,  // [1:0] kind, [2] pair_done, [3] error
  output logic       out_tlast   // end_of_value
);
  import chvp_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  chvp_res_t  out_res_r;
  logic       out_last_r;

  logic         adv;      // byte moves from input register to result register
  logic         in_xfer;
  byte_class_t  cls;
  chvp_res_t    res;
  parse_state_t state;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  chvp_byte_class u_class (
    .data_byte (s1_byte_r),
    .cls       (cls)
  );

  chvp_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cls   (cls),
    .last  (s1_last_r),
    .res   (res),
    .state (state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= s1_byte_r;
      out_res_r  <= res;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_res_r.error, out_res_r.pair_done, out_res_r.kind};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // an error byte carries no tag and closes no pair
  a_err_is_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.error |->
      (out_res_r.kind == KIND_SEP) && !out_res_r.pair_done)
    else $error("error result with tag or pair flag");

  // name bytes never close a pair
  a_name_no_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == KIND_NAME) |-> !out_res_r.pair_done)
    else $error("pair closed on a name byte");

  // the parser restarts after every final byte
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> (state == ST_OWS_START))
    else $error("parser not back at start after final byte");

  // a byte waiting behind a stalled result is not dropped
  a_hold_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input byte lost during stall");

  // the state only moves when a byte goes through
  a_state_moves_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state))
    else $error("state changed without a byte");
`endif

endmodule
